// ----- hdl/bsem_pkg.sv -----
// ----------------------------------------------------------------------------
// bsem_pkg: shared types for the block scaling element matrix unit
// Command and result words, op codes, queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package bsem_pkg;

  localparam logic [1:0] OP_WR_MATRIX  = 2'd0;
  localparam logic [1:0] OP_WR_INVERSE = 2'd1;
  localparam logic [1:0] OP_SET_FLAG   = 2'd2;
  localparam logic [1:0] OP_READ_ROW   = 2'd3;

  localparam logic signed [63:0] Q_ONE = 64'sh10000;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] entry_value;
    logic               is_prescribed;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         out_column;
    logic signed [31:0] scaled_value;
    logic               saturated;
    logic               last_in_row;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_MAC,
    BK_EMIT
  } bk_state_t;

endpackage
`default_nettype wire

// ----- hdl/bsem_front.sv -----
// ----------------------------------------------------------------------------
// bsem_front: command intake
// Accepts command words, drops out-of-range ones, queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none
module bsem_front #(
  parameter int SIZE = 12,
  parameter int DPN  = 4,
  parameter int QDEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bsem_pkg::cmd_t cmd,
  output logic               busy,
  output logic               q_valid,
  output bsem_pkg::cmd_t     q_data,
  input  wire logic          q_pop
);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  bsem_pkg::cmd_t q_mem [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   cnt;
  logic          keep, push;

  always_comb begin
    case (cmd.operation)
      bsem_pkg::OP_WR_MATRIX:
        keep = (32'(cmd.row_index) < SIZE) && (32'(cmd.col_index) < SIZE);
      bsem_pkg::OP_WR_INVERSE:
        keep = (32'(cmd.row_index) < SIZE) && (32'(cmd.col_index) < DPN);
      default:
        keep = 32'(cmd.row_index) < SIZE;
    endcase
  end

  assign busy    = (32'(cnt) == QDEPTH);
  assign push    = start && !busy && keep;
  assign q_valid = (cnt != '0);
  assign q_data  = q_mem[rp];

  always_ff @(posedge clk) begin
    if (push) q_mem[wp] <= cmd;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (32'(wp) == QDEPTH-1) ? '0 : wp + 1'b1;
      if (q_pop) rp <= (32'(rp) == QDEPTH-1) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ----- hdl/bsem_back.sv -----
// ----------------------------------------------------------------------------
// bsem_back: command execution
// Holds the stores and runs one shared MAC for row readouts.
// ----------------------------------------------------------------------------
`default_nettype none
module bsem_back #(
  parameter int SIZE = 12,
  parameter int DPN  = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire bsem_pkg::cmd_t q_data,
  output logic                q_pop,
  output logic                done,
  output bsem_pkg::res_t      result
);
  localparam int MD = SIZE*SIZE;
  localparam int ID = SIZE*DPN;
  localparam int MA = $clog2(MD);
  localparam int IA = $clog2(ID);
  localparam int CW = $clog2(SIZE);
  localparam int JW = (DPN > 1) ? $clog2(DPN) : 1;
  localparam int NPE = SIZE / DPN;

  logic signed [31:0] mat [MD];
  logic signed [31:0] inv [ID];
  logic [SIZE-1:0]    flags;

  bsem_pkg::bk_state_t state, state_next;
  logic [3:0]  row;
  logic [CW-1:0] col;
  logic [JW-1:0] j;
  logic          first;
  logic signed [31:0] w_rd, m_rd;
  logic               msk, diag;
  logic signed [65:0] acc;
  logic [3:0]  base_r;
  logic [3:0]  mrow;
  logic        last_j;
  logic        rd_v, rd_last, prod_last, emit;

  // first dof of the node that owns the requested row
  always_comb begin
    base_r = '0;
    for (int k = 1; k < NPE; k++)
      if (32'(row) >= k*DPN) base_r = 4'(k*DPN);
  end

  assign mrow   = base_r + 4'(j);
  assign last_j = (32'(j) == DPN-1);
  // last product of the column sits in prod this cycle
  assign emit   = (state == bsem_pkg::BK_EMIT) && prod_last;

  always_comb begin
    state_next = state;
    case (state)
      bsem_pkg::BK_IDLE:
        if (q_valid && q_data.operation == bsem_pkg::OP_READ_ROW)
          state_next = bsem_pkg::BK_FETCH;
      bsem_pkg::BK_FETCH: state_next = bsem_pkg::BK_MAC;
      bsem_pkg::BK_MAC: if (last_j) state_next = bsem_pkg::BK_EMIT;
      bsem_pkg::BK_EMIT:
        if (prod_last)
          state_next = (32'(col) == SIZE-1) ? bsem_pkg::BK_IDLE : bsem_pkg::BK_FETCH;
      default: state_next = bsem_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == bsem_pkg::BK_IDLE) && q_valid;
  end

  // multiply stage registered: the product feeds the accumulator next cycle
  logic signed [65:0] prod, term;
  logic signed [63:0] mul;
  logic               prod_v;
  logic signed [65:0] total, fl;
  always_comb begin
    mul   = w_rd * m_rd;
    term  = msk ? (diag ? 66'(bsem_pkg::Q_ONE * 64'(w_rd)) : 66'sd0) : 66'(mul);
    total = acc + prod;
    fl    = total >>> 16;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      case (q_data.operation)
        bsem_pkg::OP_WR_MATRIX:
          mat[MA'(32'(q_data.row_index)*SIZE + 32'(q_data.col_index))] <= q_data.entry_value;
        bsem_pkg::OP_WR_INVERSE:
          inv[IA'(32'(q_data.row_index)*DPN + 32'(q_data.col_index))] <= q_data.entry_value;
        default: ;
      endcase
    end
    // registered memory reads, one pair per MAC step
    w_rd <= inv[IA'(32'(row)*DPN + 32'(j))];
    m_rd <= mat[MA'(32'(mrow)*SIZE + 32'(col))];
    msk  <= flags[mrow[CW-1:0]] || flags[col];
    diag <= (32'(mrow) == 32'(col));
    prod <= term;
    if (rst) begin
      state <= bsem_pkg::BK_IDLE;
      flags <= '0;
      rd_v <= 1'b0;
      rd_last <= 1'b0;
      prod_v <= 1'b0;
      prod_last <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop && q_data.operation == bsem_pkg::OP_SET_FLAG)
        flags[q_data.row_index[CW-1:0]] <= q_data.is_prescribed;
      // read data is valid in the cycle after the address; the product is registered behind it
      rd_v <= (state == bsem_pkg::BK_MAC);
      rd_last <= (state == bsem_pkg::BK_MAC) && last_j;
      prod_v <= rd_v;
      prod_last <= rd_last;
      done <= emit;
      if (prod_v) begin
        acc <= first ? prod : total;
        first <= 1'b0;
      end
      case (state)
        bsem_pkg::BK_IDLE:
          if (q_pop) begin row <= q_data.row_index; col <= '0; j <= '0; end
        bsem_pkg::BK_FETCH: begin j <= '0; first <= 1'b1; end
        bsem_pkg::BK_MAC: if (!last_j) j <= j + 1'b1;
        default: ;
      endcase
    end
    // emit once the last product has been folded in
    if (!rst && emit) begin
      result.out_column <= 4'(col);
      result.last_in_row <= (32'(col) == SIZE-1);
      if (first ? (prod >>> 16) > 64'sh7FFFFFFF : fl > 64'sh7FFFFFFF) begin
        result.scaled_value <= 32'sh7FFFFFFF; result.saturated <= 1'b1;
      end else if ((first ? (prod >>> 16) : fl) < -64'sh80000000) begin
        result.scaled_value <= 32'sh80000000; result.saturated <= 1'b1;
      end else begin
        result.scaled_value <= first ? 32'(prod >>> 16) : 32'(fl);
        result.saturated <= 1'b0;
      end
      col <= col + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/block_scale_element_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// block_scale_element_matrix_unit: block Jacobi scaling of an element matrix
// Loads matrix, inverse blocks and prescribed flags; reads scaled rows.
// ----------------------------------------------------------------------------
// channel  | ports                  | handshake
// command  | start, busy, cmd       | taken when start && !busy
// result   | done, result           | one word per cycle of done, no stall
//
// Write words are applied in the back end as they are dequeued. A row readout
// is dequeued, then produces SIZE words through the single shared MAC (one
// setup step, one memory read per product, then the read and multiply stages
// drain before the saturated word goes out). A short queue lets the host
// keep issuing words while a readout runs; busy rises only when it is full.
// Synchronous reset clears the queue, the sequencer and the flags.
`default_nettype none
module block_scale_element_matrix_unit #(
  parameter int DOFS_PER_NODE = 4,
  parameter int NODES_PER_ELEMENT = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire bsem_pkg::cmd_t cmd,
  output logic                busy,
  output logic                done,
  output bsem_pkg::res_t      result
);
  localparam int SIZE = DOFS_PER_NODE * NODES_PER_ELEMENT;

  logic           q_valid, q_pop;
  bsem_pkg::cmd_t q_data;

  bsem_front #(.SIZE(SIZE), .DPN(DOFS_PER_NODE), .QDEPTH(2)) u_front (
    .clk, .rst, .start, .cmd, .busy, .q_valid, .q_data, .q_pop
  );

  bsem_back #(.SIZE(SIZE), .DPN(DOFS_PER_NODE)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .done, .result
  );
endmodule
`default_nettype wire
